// ----- rtl/uera_pkg.sv -----
// shared widths, command and status types for the echo range averager
`timescale 1ns / 1ps
`default_nettype none

package uera_pkg;

  localparam int TICKS_W    = 16;
  localparam int SPACING_W  = 8;
  localparam int OFFSET_W   = 10;
  localparam int RANGE_W    = 21;
  localparam int SUM_W      = 24;
  localparam int COUNT_W    = 4;
  localparam int SLANT_W    = 21;
  localparam int SP2_W      = 2 * SPACING_W;
  localparam int CORR_W     = 21;
  localparam int RAD_W      = 2 * SLANT_W;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int STEP_W     = $clog2(SQRT_STEPS);

  // reciprocal of the run length, exact for any sum below 2^SUM_W and length up to 15
  localparam int RECIP_SHIFT = SUM_W + COUNT_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPACING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 2'd1;

  localparam logic [SPACING_W-1:0] SPACING_RESET = 8'd0;
  localparam logic [OFFSET_W-1:0]  OFFSET_RESET  = 10'd120;

  localparam int SAMPLES_DEFAULT = 5;

  typedef struct packed {
    logic load;       // input transfer taken
    logic mul;        // square slant and spacing term
    logic rad_load;   // form radicand, start root
    logic sqrt_step;
    logic acc;        // add single range into run
    logic div_step;   // run sum times reciprocal of run length
    logic emit;       // move result into output register
  } uera_cmd_t;

  typedef struct packed {
    logic run_done;
  } uera_sts_t;

endpackage

`default_nettype wire

// ----- rtl/ultrasonic_echo_range_average.sv -----
// top level: echo pulse width to averaged range in tenths of a millimetre
//
//   port group   dir  handshake             payload
//   input        in   in_valid_i/in_stall_o  echo_ticks_i, timed_out_i
//   result       out  out_valid_o/out_stall_i range_tenth_mm_o, timeout_flag_o
//   config       in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a pulse that does not close a run goes from transfer to the next transfer through
// square, radicand, 21 root steps of one bit each, accumulate
// a pulse that closes a run adds a reciprocal multiply, then emit once the output is free
// a timeout pulse goes from transfer straight to emit; results leave through an output register
// reset clears the run sum, count and config registers (offset back to 120)
// the input stalls while an item is in work or its result cannot be placed
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_range_average
  import uera_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEFAULT
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire [TICKS_W-1:0]     echo_ticks_i,
  input  wire                   timed_out_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic [RANGE_W-1:0]    range_tenth_mm_o,
  output logic                  timeout_flag_o,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [CFG_DATA_W-1:0]  cfg_data_i
);

  uera_cmd_t cmd;
  uera_sts_t sts;

  assign cfg_ready_o = 1'b1;

  uera_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .timed_out_i (timed_out_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  uera_dp #(
    .SAMPLES (SAMPLES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .echo_ticks_i     (echo_ticks_i),
    .timed_out_i      (timed_out_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .range_tenth_mm_o (range_tenth_mm_o),
    .timeout_flag_o   (timeout_flag_o)
  );

endmodule

`default_nettype wire

// ----- rtl/uera_dp.sv -----
// datapath: config registers, slant square, iterative root, run sum, divider
`timescale 1ns / 1ps
`default_nettype none

module uera_dp
  import uera_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEFAULT
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire [TICKS_W-1:0]     echo_ticks_i,
  input  wire                   timed_out_i,
  input  uera_cmd_t             cmd_i,
  output uera_sts_t             sts_o,
  output logic [RANGE_W-1:0]    range_tenth_mm_o,
  output logic                  timeout_flag_o
);

  localparam int RUN_LEN_I = (SAMPLES < 1) ? 1 : SAMPLES;
  localparam logic [COUNT_W-1:0] RUN_LEN = COUNT_W'(RUN_LEN_I);
  localparam logic [SUM_W-1:0]   SUM_MAX = {SUM_W{1'b1}};
  localparam logic [RECIP_W-1:0] RECIP   =
    RECIP_W'(((1 << RECIP_SHIFT) + RUN_LEN_I - 1) / RUN_LEN_I);
  localparam int PROD_W = SUM_W + RECIP_W;

  logic [SPACING_W-1:0] spacing_q;
  logic [OFFSET_W-1:0]  offset_q;
  logic [SUM_W-1:0]     sum_q;
  logic [COUNT_W-1:0]   count_q;

  logic [SLANT_W-1:0]   slant_q;
  logic [SP2_W-1:0]     sp2_q;
  logic [RAD_W-1:0]     sq_q;
  logic [CORR_W-1:0]    corr_q;
  logic [RAD_W-1:0]     rad_q;
  logic [REM_W-1:0]     rem_q;
  logic [ROOT_W-1:0]    root_q;
  logic [SUM_W-1:0]     quo_q;
  logic                 to_q;
  logic [RANGE_W-1:0]   range_q;
  logic                 flag_q;

  logic [SLANT_W-1:0]   slant_d;
  logic [RAD_W-1:0]     sq_d;
  logic [CORR_W-1:0]    corr_d;
  logic [RAD_W-1:0]     rad_d;
  logic [REM_W-1:0]     sq_trial;
  logic [REM_W-1:0]     sq_part;
  logic                 sq_ge;
  logic [SUM_W-1:0]     single;
  logic [SUM_W:0]       sum_ext;
  logic [SUM_W-1:0]     sum_d;
  logic [COUNT_W-1:0]   count_inc;
  logic [PROD_W-1:0]    dv_prod;

  // 17 * ticks as shift and add
  assign slant_d = SLANT_W'({echo_ticks_i, 4'b0000}) + SLANT_W'(echo_ticks_i);
  assign sq_d    = RAD_W'(slant_q) * RAD_W'(slant_q);
  // 25 * spacing^2, the square of half the spacing in tenths of mm
  assign corr_d  = CORR_W'({sp2_q, 4'b0000}) + CORR_W'({sp2_q, 3'b000})
                 + CORR_W'(sp2_q);
  assign rad_d   = (sq_q > RAD_W'(corr_q)) ? (sq_q - RAD_W'(corr_q)) : '0;

  // one result bit per step, two radicand bits shifted in
  assign sq_part  = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
  assign sq_trial = {root_q, 2'b01};
  assign sq_ge    = (sq_part >= sq_trial);

  assign single    = SUM_W'(root_q) + SUM_W'(offset_q);
  assign sum_ext   = {1'b0, sum_q} + {1'b0, single};
  assign sum_d     = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
  assign count_inc = count_q + COUNT_W'(1);
  assign sts_o.run_done = (count_inc >= RUN_LEN);

  // divide by the run length as a multiply by its rounded-up reciprocal
  assign dv_prod = PROD_W'(quo_q) * PROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= SPACING_RESET;
      offset_q  <= OFFSET_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SPACING: spacing_q <= cfg_data_i[SPACING_W-1:0];
        REG_OFFSET:  offset_q  <= cfg_data_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.load && timed_out_i) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.acc) begin
      if (sts_o.run_done) begin
        sum_q   <= '0;
        count_q <= '0;
      end else begin
        sum_q   <= sum_d;
        count_q <= count_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      slant_q <= slant_d;
      sp2_q   <= spacing_q * spacing_q;
      to_q    <= timed_out_i;
    end
    if (cmd_i.mul) begin
      sq_q   <= sq_d;
      corr_q <= corr_d;
    end
    if (cmd_i.rad_load) begin
      rad_q  <= rad_d;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= sq_ge ? (sq_part - sq_trial) : sq_part;
      root_q <= {root_q[ROOT_W-2:0], sq_ge};
    end
    if (cmd_i.acc) begin
      quo_q <= sum_d;
    end else if (cmd_i.div_step) begin
      quo_q <= dv_prod[RECIP_SHIFT +: SUM_W];
    end
    if (cmd_i.emit) begin
      range_q <= to_q ? '0 : quo_q[RANGE_W-1:0];
      flag_q  <= to_q;
    end
  end

  assign range_tenth_mm_o = range_q;
  assign timeout_flag_o   = flag_q;

endmodule

`default_nettype wire

// ----- rtl/uera_ctrl.sv -----
// controller: sequences one item through square, root and sum, divide at run end; timeouts go to emit
`timescale 1ns / 1ps
`default_nettype none

module uera_ctrl
  import uera_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        timed_out_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  input  uera_sts_t  sts_i,
  output uera_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_RAD  = 3'd2;
  localparam logic [2:0] ST_SQRT = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = timed_out_i ? ST_EMIT : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_RAD;
      end
      ST_RAD: begin
        cmd_o.rad_load = 1'b1;
        step_d         = '0;
        state_d        = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        step_d          = step_q + STEP_W'(1);
        if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        step_d    = '0;
        state_d   = sts_i.run_done ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input transfer did not start work");

  a_emit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> out_free)
    else $error("result overwrote a waiting result");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
    else $error("result valid without emit");

  a_sqrt_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (step_q < STEP_W'(SQRT_STEPS)))
    else $error("root step count out of range");

  a_one_busy_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.mul, cmd_o.rad_load, cmd_o.sqrt_step,
              cmd_o.acc, cmd_o.div_step, cmd_o.emit}))
    else $error("more than one datapath command");

endmodule

`default_nettype wire

// ----- dv/echo_range_checker.sv -----
// checker for the echo range averager: watches all channels, predicts ranges, compares
`timescale 1ns / 1ps

module echo_range_checker
  import uera_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEFAULT
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  in_stall_i,
  input  wire [TICKS_W-1:0]    echo_ticks_i,
  input  wire                  timed_out_i,
  input  wire                  out_valid_i,
  input  wire                  out_stall_i,
  input  wire [RANGE_W-1:0]    range_tenth_mm_i,
  input  wire                  timeout_flag_i,
  input  wire                  cfg_valid_i,
  input  wire                  cfg_ready_i,
  input  wire [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [CFG_DATA_W-1:0] cfg_data_i,
  output int                   mismatches_o,
  output int                   pending_o,
  output int                   results_o,
  output int                   timeouts_o,
  output int                   clamped_o
);

  localparam int RUN_LEN = (SAMPLES < 1) ? 1 : SAMPLES;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef struct packed {
    logic [RANGE_W-1:0] avg_range;
    logic               timeout;
  } echo_result_t;

  logic [SPACING_W-1:0] spacing_q;
  logic [OFFSET_W-1:0]  offset_q;
  logic [SUM_W-1:0]     run_sum;
  logic [COUNT_W-1:0]   run_count;
  echo_result_t         expected_ranges[$];

  // floor of the square root, two radicand bits per step
  function automatic logic [ROOT_W-1:0] floor_root(input logic [RAD_W-1:0] rad);
    logic [RAD_W-1:0] rem;
    logic [RAD_W-1:0] root;
    logic [RAD_W-1:0] probe;
    rem   = rad;
    root  = '0;
    probe = {{(RAD_W-1){1'b0}}, 1'b1} << (RAD_W - 2);
    for (int k = 0; k < RAD_W / 2; k++) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root[ROOT_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    logic [RAD_W-1:0] slant;
    logic [RAD_W-1:0] slant_sq;
    logic [RAD_W-1:0] spacing_term;
    logic [RAD_W-1:0] radicand;
    logic [SUM_W-1:0] single;
    logic [SUM_W:0]   sum_next;
    echo_result_t     want;
    echo_result_t     got;
    if (!rst_ni) begin
      spacing_q = SPACING_RESET;
      offset_q  = OFFSET_RESET;
      run_sum   = '0;
      run_count = '0;
      expected_ranges.delete();
      mismatches_o = 0;
      results_o    = 0;
      timeouts_o   = 0;
      clamped_o    = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SPACING: spacing_q = cfg_data_i[SPACING_W-1:0];
          REG_OFFSET:  offset_q  = cfg_data_i[OFFSET_W-1:0];
          default: ;
        endcase
      end

      // results first, so a spurious one never pairs with an item taken at this edge
      if (out_valid_i && !out_stall_i) begin
        got.avg_range = range_tenth_mm_i;
        got.timeout   = timeout_flag_i;
        if (expected_ranges.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t: result with none pending: range %0d flag %0b",
                     $time, got.avg_range, got.timeout);
        end else begin
          want = expected_ranges.pop_front();
          results_o++;
          if (want.timeout)
            timeouts_o++;
          if (got.avg_range !== want.avg_range || got.timeout !== want.timeout) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("%0t: result mismatch: range want %0d got %0d, flag want %0b got %0b",
                       $time, want.avg_range, got.avg_range, want.timeout, got.timeout);
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (timed_out_i) begin
          run_sum   = '0;
          run_count = '0;
          want.avg_range = '0;
          want.timeout   = 1'b1;
          expected_ranges.push_back(want);
        end else begin
          slant        = RAD_W'(echo_ticks_i) * 17;
          slant_sq     = slant * slant;
          spacing_term = RAD_W'(spacing_q) * RAD_W'(spacing_q) * 25;
          // spacing term larger than the slant path: range is the offset alone
          if (slant_sq > spacing_term) begin
            radicand = slant_sq - spacing_term;
          end else begin
            radicand = '0;
            if (slant_sq < spacing_term)
              clamped_o++;
          end
          single   = SUM_W'(floor_root(radicand)) + SUM_W'(offset_q);
          sum_next = {1'b0, run_sum} + {1'b0, single};
          run_sum  = (sum_next > {1'b0, SUM_MAX}) ? SUM_MAX : sum_next[SUM_W-1:0];
          run_count = run_count + 1'b1;
          if (run_count >= RUN_LEN) begin
            want.avg_range = RANGE_W'(run_sum / RUN_LEN);
            want.timeout   = 1'b0;
            expected_ranges.push_back(want);
            run_sum   = '0;
            run_count = '0;
          end
        end
      end
      pending_o = expected_ranges.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
// testbench top: drives echo pulses and register writes into the range averager
`timescale 1ns / 1ps

module tb;
  import uera_pkg::*;

  localparam int RUN_LEN       = SAMPLES_DEFAULT;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 135;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [TICKS_W-1:0]    echo_ticks;
  logic                  timed_out;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [RANGE_W-1:0]    range_tenth_mm;
  logic                  timeout_flag;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int pending;
  int results;
  int timeouts;
  int clamped;

  logic tx_quiet = 1'b0;
  logic rx_quiet = 1'b0;
  logic rx_hold  = 1'b0;
  logic rx_busy  = 1'b0;
  int   rx_left  = 0;
  int   cur_spacing = 0;
  int   pulses_sent = 0;
  int   reg_writes  = 0;

  ultrasonic_echo_range_average #(
    .SAMPLES(RUN_LEN)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .echo_ticks_i    (echo_ticks),
    .timed_out_i     (timed_out),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .range_tenth_mm_o(range_tenth_mm),
    .timeout_flag_o  (timeout_flag),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  echo_range_checker #(
    .SAMPLES(RUN_LEN)
  ) i_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .echo_ticks_i    (echo_ticks),
    .timed_out_i     (timed_out),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .range_tenth_mm_i(range_tenth_mm),
    .timeout_flag_i  (timeout_flag),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .results_o       (results),
    .timeouts_o      (timeouts),
    .clamped_o       (clamped)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [TICKS_W-1:0] pick_ticks();
    int r;
    int thr;
    r = $urandom_range(0, 99);
    if (r < 40) return TICKS_W'($urandom);
    if (r < 55) return TICKS_W'($urandom_range(0, 120));
    if (r < 70) return TICKS_W'($urandom_range(60000, 65535));
    if (r < 85) begin
      // around the point where the slant path equals half the spacing
      thr = (5 * cur_spacing) / 17 - 1;
      if (thr < 0) thr = 0;
      return TICKS_W'(thr + $urandom_range(0, 4));
    end
    return TICKS_W'($urandom_range(0, 4000));
  endfunction

  // receiver side: random stall bursts plus the long hold-off
  always @(negedge clk) begin : rx_side
    int n;
    if (!rst_n || rx_quiet) begin
      rx_left = 0;
      rx_busy = 1'b0;
    end else if (rx_left > 0) begin
      rx_left--;
    end else begin
      n = gap_len();
      rx_busy = (n > 0);
      rx_left = (n > 0) ? n - 1 : 0;
    end
    out_stall = rx_busy | rx_hold;
  end

  task automatic send_pulse(input logic [TICKS_W-1:0] ticks, input logic to);
    int n;
    n = tx_quiet ? 0 : gap_len();
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid   = 1'b1;
    echo_ticks = ticks;
    timed_out  = to;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    pulses_sent++;
  endtask

  // wait until every result is out and any item without a result has finished
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == REG_SPACING)
      cur_spacing = int'(data[SPACING_W-1:0]);
    reg_writes++;
  endtask

  task automatic configure(input int spacing, input int offset);
    logic [CFG_DATA_W-1:0] sp_word;
    sp_word = CFG_DATA_W'(spacing);
    // unused upper data bits must not reach the spacing register
    if ($urandom_range(0, 1))
      sp_word[CFG_DATA_W-1:SPACING_W] = (CFG_DATA_W - SPACING_W)'($urandom);
    if ($urandom_range(0, 1)) begin
      write_reg(REG_SPACING, sp_word);
      write_reg(REG_OFFSET, CFG_DATA_W'(offset));
    end else begin
      write_reg(REG_OFFSET, CFG_DATA_W'(offset));
      write_reg(REG_SPACING, sp_word);
    end
  endtask

  // mostly complete runs, some lone timeouts and runs cut short by a timeout
  task automatic run_phase(input int n_items);
    int k;
    int r;
    int len;
    k = 0;
    while (k < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_pulse(pick_ticks(), 1'b1);
        k++;
      end else if (r < 16) begin
        len = $urandom_range(1, RUN_LEN - 1);
        repeat (len) send_pulse(pick_ticks(), 1'b0);
        send_pulse(pick_ticks(), 1'b1);
        k += len + 1;
      end else begin
        repeat (RUN_LEN) send_pulse(pick_ticks(), 1'b0);
        k += RUN_LEN;
      end
    end
  endtask

  initial begin : stimulus
    int phase_spacing[PHASES];
    int phase_offset[PHASES];
    int sp;
    int off;
    phase_spacing = '{0, 255, -1, 255, -1, -1, 0, -1};
    phase_offset  = '{1023, 0, -1, 1023, -1, 0, -1, -1};
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    echo_ticks = '0;
    timed_out  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_SPACING;
    cfg_data   = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // directed: reset settings, field extremes, timeouts alone and mid-run
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    send_pulse(16'h0000, 1'b0);
    send_pulse(16'hFFFF, 1'b0);
    send_pulse(16'h0001, 1'b0);
    send_pulse(16'h5555, 1'b0);
    send_pulse(16'hAAAA, 1'b0);
    send_pulse(16'hFFFF, 1'b1);
    send_pulse(16'h0000, 1'b1);
    send_pulse(16'd300, 1'b0);
    send_pulse(16'hFFFF, 1'b0);
    send_pulse(16'd7, 1'b1);
    settle();

    // widest spacing: slant path below, at and above half the spacing
    configure(255, 1023);
    send_pulse(16'd0, 1'b0);
    send_pulse(16'd74, 1'b0);
    send_pulse(16'd75, 1'b0);
    send_pulse(16'd76, 1'b0);
    send_pulse(16'hFFFF, 1'b0);
    settle();

    // all zero run must come out as range zero without the flag
    configure(0, 0);
    repeat (RUN_LEN) send_pulse(16'd0, 1'b0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      sp  = (phase_spacing[p] < 0) ? $urandom_range(0, 255) : phase_spacing[p];
      off = (phase_offset[p] < 0) ? $urandom_range(0, 1023) : phase_offset[p];
      configure(sp, off);
      tx_quiet = (p == 3) || (p == 5);
      rx_quiet = (p == 3);
      if (p == 2) begin
        // receiver holds off while pulses keep coming, so the block backs up
        fork
          begin
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            rx_hold = 1'b0;
          end
        join_none
        tx_quiet = 1'b1;
        run_phase(40);
        tx_quiet = 1'b0;
        run_phase(PHASE_ITEMS - 40);
      end else begin
        run_phase(PHASE_ITEMS);
      end
      settle();
    end

    $display("run covered %0d echo pulses and %0d register writes, %0d below half spacing",
             pulses_sent, reg_writes, clamped);
    $display("checked %0d results, %0d of them timeouts, %0d mismatches",
             results, timeouts, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
